@@ rtl/pcrpl_pkg.sv @@
// Shared types and constants for the per-cluster ranked probe lists block.
// No dependencies; used by pcrpl_rank and per_cluster_ranked_probe_lists_top.
package pcrpl_pkg;

  // Default sizes
  localparam int CLUSTERS_DEF = 4096;
  localparam int MAX_K_DEF    = 8;

  // Register reset values
  localparam logic [3:0]  MAX_PER_CLUSTER_RST = 4'd8;
  localparam logic [15:0] MAX_REFERENCES_RST  = 16'hFFFF;

  // Operation codes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_PUBLISH = 2'd1;
  localparam logic [1:0] OP_FRAME   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_PER_CLUSTER = 2'd0;
  localparam logic [1:0] CFG_MAX_REFERENCES  = 2'd1;

  // One stored list entry
  typedef struct packed {
    logic [9:0]  slot;
    logic [15:0] influence;
    logic [7:0]  prio;
    logic [31:0] volume;
    logic [31:0] owner;
  } entry_t;

endpackage

@@ rtl/pcrpl_rank.sv @@
// Rank compare unit: tells whether a candidate ranks strictly ahead of an entry.
// Depends on pcrpl_pkg (entry_t).
module pcrpl_rank (
  input  pcrpl_pkg::entry_t cand,
  input  pcrpl_pkg::entry_t stored,
  output logic              ahead
);

  // Higher priority, then higher influence, then smaller volume, then smaller owner
  always_comb begin
    if (cand.prio != stored.prio) begin
      ahead = cand.prio > stored.prio;
    end else if (cand.influence != stored.influence) begin
      ahead = cand.influence > stored.influence;
    end else if (cand.volume != stored.volume) begin
      ahead = cand.volume < stored.volume;
    end else begin
      ahead = cand.owner < stored.owner;
    end
  end

endmodule

@@ rtl/per_cluster_ranked_probe_lists_top.sv @@
// Top level: sequencer, list and counter memories, frame statistics.
// Depends on pcrpl_pkg and pcrpl_rank.
//
// A request is taken when start is high and busy is low. An insert compares the candidate
// against kept entries (at most the kept count), visited one entry a cycle from the list
// tail upward through the single read port of the entry memory. A publish returns
// max(1, published count) results, one per cycle, each marked by result_valid for a single
// cycle; the receiver cannot stall them. A begin frame clears the frame statistics. After
// reset the block runs a clearing pass over every word of the per-cluster counter memory
// with busy high; configuration writes are taken at any time.
module per_cluster_ranked_probe_lists_top #(
  parameter int CLUSTERS = pcrpl_pkg::CLUSTERS_DEF,
  parameter int MAX_K    = pcrpl_pkg::MAX_K_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [11:0] cluster,
  input  logic [9:0]  slot,
  input  logic [15:0] influence,
  input  logic [7:0]  priority_req,
  input  logic [31:0] influence_volume,
  input  logic [31:0] owner,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  output logic [15:0] header_offset,
  output logic [3:0]  header_count,
  output logic [9:0]  probe_slot,
  output logic        slot_valid,
  output logic        last,
  output logic [31:0] cluster_requested,
  output logic [31:0] requested_total,
  output logic [31:0] max_requested,
  output logic [12:0] clusters_used,
  output logic [15:0] published_total,
  output logic        capacity_overflow
);

  localparam int CW     = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int KW     = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CNTW   = $clog2(MAX_K + 2);
  localparam int MW     = CNTW + 32;
  localparam int EDEPTH = CLUSTERS * (2 ** KW);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_META  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_PLACE = 8'b0001_0000,
    S_PSTAT = 8'b0010_0000,
    S_PSUM  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state;

  // Captured request
  logic [1:0]         op_r;
  logic [CW-1:0]      idx_r;
  logic               inr_r;
  pcrpl_pkg::entry_t  cand;

  // Sequencer registers
  logic [CNTW-1:0] count_r;
  logic [31:0]     req_r;
  logic [CNTW-1:0] cur;
  logic [CNTW-1:0] pos;
  logic [CW-1:0]   clr_idx;
  logic [15:0]     avail;
  logic [CNTW-1:0] pub;
  logic [15:0]     offset;
  logic [CNTW-1:0] j;

  // Configuration and frame statistics
  logic [3:0]  max_per_cluster;
  logic [15:0] max_references;
  logic [15:0] pub_sum;
  logic [31:0] req_sum;
  logic [31:0] req_peak;
  logic [12:0] used;
  logic        ovf;

  // Memories
  logic [MW-1:0]     meta_mem [CLUSTERS];
  logic [MW-1:0]     meta_rd;
  pcrpl_pkg::entry_t entry_mem [EDEPTH];
  pcrpl_pkg::entry_t e_rd;

  logic [CW-1:0]          m_raddr, m_waddr;
  logic                   m_we;
  logic [MW-1:0]          m_wdata;
  logic [CW+KW-1:0]       e_raddr, e_waddr;
  logic                   e_we;
  pcrpl_pkg::entry_t      e_wdata;

  logic [CNTW-1:0] meta_count;
  logic [31:0]     meta_req;
  logic [CNTW-1:0] k_lim;
  logic [CNTW-1:0] n_new;
  logic [CNTW-1:0] nres;
  logic            is_last;
  logic            ahead;
  logic            accept;
  logic [32:0]     sum_wide;
  logic [CNTW-1:0] kept_v;
  logic [31:0]     req_v;

  assign busy       = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = start && !busy;
  assign meta_count = meta_rd[MW-1:32];
  assign meta_req   = meta_rd[31:0];
  assign n_new      = (count_r + CNTW'(1) > k_lim) ? k_lim : count_r + CNTW'(1);
  assign nres       = (pub == '0) ? CNTW'(1) : pub;
  assign is_last    = (j + CNTW'(1) == nres);
  assign kept_v     = inr_r ? meta_count : '0;
  assign req_v      = inr_r ? meta_req : '0;
  assign sum_wide   = {1'b0, req_sum} + {1'b0, req_r};

  // Saturate the list limit into 1..MAX_K
  always_comb begin
    if (max_per_cluster == 4'd0) begin
      k_lim = CNTW'(1);
    end else if (32'(max_per_cluster) > 32'(MAX_K)) begin
      k_lim = CNTW'(MAX_K);
    end else begin
      k_lim = CNTW'(max_per_cluster);
    end
  end

  pcrpl_rank u_rank (
    .cand   (cand),
    .stored (e_rd),
    .ahead  (ahead)
  );

  // Memory port control
  always_comb begin
    m_raddr = CW'(cluster);
    m_we    = 1'b0;
    m_waddr = idx_r;
    m_wdata = '0;
    e_raddr = {idx_r, KW'(0)};
    e_we    = 1'b0;
    e_waddr = {idx_r, KW'(0)};
    e_wdata = cand;
    case (state)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_idx;
      end
      S_META: begin
        e_raddr = {idx_r, KW'(meta_count - CNTW'(1))};
      end
      S_SCAN: begin
        // Push the visited entry one place down when the candidate beats it and that place is within the list limit
        if (ahead && (cur + CNTW'(1) < k_lim)) begin
          e_we    = 1'b1;
          e_waddr = {idx_r, KW'(cur + CNTW'(1))};
          e_wdata = e_rd;
        end
        e_raddr = {idx_r, KW'(cur - CNTW'(1))};
      end
      S_PLACE: begin
        m_we    = 1'b1;
        m_wdata = {((pos < k_lim) ? n_new : count_r), req_r};
        e_we    = (pos < k_lim);
        e_waddr = {idx_r, KW'(pos)};
      end
      S_PSTAT: begin
        m_we = inr_r;
      end
      S_EMIT: begin
        e_raddr = {idx_r, KW'(j + CNTW'(1))};
      end
      default: begin
      end
    endcase
  end

  // Counter memory
  always_ff @(posedge clk) begin
    if (m_we) begin
      meta_mem[m_waddr] <= m_wdata;
    end
    meta_rd <= meta_mem[m_raddr];
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (e_we) begin
      entry_mem[e_waddr] <= e_wdata;
    end
    e_rd <= entry_mem[e_raddr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_per_cluster <= pcrpl_pkg::MAX_PER_CLUSTER_RST;
      max_references  <= pcrpl_pkg::MAX_REFERENCES_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pcrpl_pkg::CFG_MAX_PER_CLUSTER) begin
        max_per_cluster <= cfg_data[3:0];
      end else if (cfg_index == pcrpl_pkg::CFG_MAX_REFERENCES) begin
        max_references <= cfg_data;
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= operation;
      idx_r <= CW'(cluster);
      inr_r <= 32'(cluster) < 32'(CLUSTERS);
      cand  <= '{slot: slot, influence: influence, prio: priority_req,
                 volume: influence_volume, owner: owner};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      pub_sum      <= '0;
      req_sum      <= '0;
      req_peak     <= '0;
      used         <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + CW'(1);
          if (clr_idx == CW'(CLUSTERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (operation)
              pcrpl_pkg::OP_INSERT:  state <= S_META;
              pcrpl_pkg::OP_PUBLISH: state <= S_META;
              pcrpl_pkg::OP_FRAME: begin
                pub_sum  <= '0;
                req_sum  <= '0;
                req_peak <= '0;
                used     <= '0;
                ovf      <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_META: begin
          if (op_r == pcrpl_pkg::OP_INSERT) begin
            // Count the request, then scan from the list tail, or place at once into an empty list
            count_r <= meta_count;
            req_r   <= (meta_req == '1) ? meta_req : meta_req + 32'd1;
            cur     <= meta_count - CNTW'(1);
            pos     <= '0;
            if (!inr_r) begin
              state <= S_IDLE;
            end else if (meta_count == '0) begin
              state <= S_PLACE;
            end else begin
              state <= S_SCAN;
            end
          end else begin
            count_r <= kept_v;
            req_r   <= req_v;
            state   <= S_PSTAT;
          end
        end
        S_SCAN: begin
          if (ahead) begin
            if (cur == '0) begin
              pos   <= '0;
              state <= S_PLACE;
            end else begin
              cur <= cur - CNTW'(1);
            end
          end else begin
            pos   <= cur + CNTW'(1);
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          state <= S_IDLE;
        end
        S_PSTAT: begin
          // Fold this cluster's request count into the frame totals
          req_sum <= sum_wide[32] ? '1 : sum_wide[31:0];
          if (req_r > req_peak) begin
            req_peak <= req_r;
          end
          if (req_r != '0 && used != '1) begin
            used <= used + 13'd1;
          end
          avail <= (pub_sum >= max_references) ? '0 : max_references - pub_sum;
          state <= S_PSUM;
        end
        S_PSUM: begin
          if (32'(count_r) < 32'(avail)) begin
            pub     <= count_r;
            pub_sum <= pub_sum + 16'(count_r);
          end else begin
            pub     <= CNTW'(avail);
            pub_sum <= pub_sum + avail;
            if (32'(count_r) > 32'(avail)) begin
              ovf <= 1'b1;
            end
          end
          offset <= pub_sum;
          j      <= '0;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          result_valid      <= 1'b1;
          header_offset     <= offset;
          header_count      <= 4'(pub);
          probe_slot        <= (pub != '0) ? e_rd.slot : '0;
          slot_valid        <= (pub != '0);
          last              <= is_last;
          cluster_requested <= req_r;
          requested_total   <= req_sum;
          max_requested     <= req_peak;
          clusters_used     <= used;
          published_total   <= pub_sum;
          capacity_overflow <= ovf;
          j                 <= j + CNTW'(1);
          if (is_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result only follows an emit cycle
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_EMIT))
    else $error("result without emit cycle");

  // Published count never exceeds the kept count
  a_pub_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (pub <= count_r))
    else $error("published more than kept");

  // No shift write lands beyond the list limit
  a_shift_in_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && e_we) |-> (cur + CNTW'(1) < k_lim))
    else $error("shift beyond list limit");

  // Slot flag and count agree on every result unless the published count exceeds 15
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (slot_valid == (header_count != 4'd0) || pub > CNTW'(15)))
    else $error("slot_valid disagrees with header_count");
`endif

endmodule
